// ----- hw/rtl/programmable_sound_generator_macros.svh -----
// Assertion macros used by the checker file psg_chk.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PROGRAMMABLE_SOUND_GENERATOR_MACROS_SVH
`define PROGRAMMABLE_SOUND_GENERATOR_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PSG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sound generator check failed");

// Consequent must hold in the same cycle as the antecedent.
`define PSG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sound generator check failed");

`endif

// ----- hw/rtl/psg_pkg.sv -----
// ----------------------------------------------------------------------------
// psg_pkg
// Types, register numbers and the level table of the sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

	localparam logic [3:0] REG_ENABLE = 4'd7;
	localparam logic [3:0] REG_NOISE  = 4'd6;
	localparam logic [3:0] REG_ENV_LO = 4'd11;
	localparam logic [3:0] REG_ENV_HI = 4'd12;
	localparam logic [3:0] REG_SHAPE  = 4'd13;

	localparam logic [16:0] NOISE_TAPS = 17'h24000;

	// 1.5 dB steps, entry 0 silent
	localparam logic [7:0] LEVEL_ROM [32] = '{
		8'd0,   8'd1,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,
		8'd5,   8'd6,   8'd7,   8'd8,   8'd10,  8'd11,  8'd14,  8'd16,
		8'd19,  8'd23,  8'd27,  8'd32,  8'd38,  8'd45,  8'd54,  8'd64,
		8'd76,  8'd90,  8'd108, 8'd128, 8'd152, 8'd181, 8'd215, 8'd255
	};

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_WR     = 13'b0000000000010,
		ST_PRE    = 13'b0000000000100,
		ST_NSEG   = 13'b0000000001000,
		ST_VLOOP  = 13'b0000000010000,
		ST_VFIN   = 13'b0000000100000,
		ST_NSTEP  = 13'b0000001000000,
		ST_ENV    = 13'b0000010000000,
		ST_ELOOP  = 13'b0000100000000,
		ST_EFIN   = 13'b0001000000000,
		ST_EAPPLY = 13'b0010000000000,
		ST_MIX    = 13'b0100000000000,
		ST_OUT    = 13'b1000000000000
	} state_t;

	typedef struct packed {
		logic       load;
		logic       wr;
		logic       pre;
		logic       nseg;
		logic       vstep;
		logic       vfin;
		logic       nstep;
		logic       env;
		logic       estep;
		logic       efin;
		logic       eapply;
		logic       mix;
		logic [1:0] mix_idx;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic shape_wr;
		logic vbusy;
		logic seg_last;
		logic env_go;
		logic env_more;
		logic out_free;
	} stat_t;

	function automatic logic [7:0] level(input logic [4:0] idx);
		return LEVEL_ROM[idx];
	endfunction

endpackage

// ----- hw/rtl/psg_ctrl.sv -----
// ----------------------------------------------------------------------------
// psg_ctrl
// Sequencer: steps the datapath through a register write or one sample.
// ----------------------------------------------------------------------------
module psg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              kind,
	output logic              in_ready,
	input  psg_pkg::stat_t    stat,
	output psg_pkg::cmd_t     cmd
);

	psg_pkg::state_t state_q, state_d;
	logic            kind_q;
	logic [1:0]      mix_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == psg_pkg::ST_IDLE);
		cmd.mix_idx = mix_q;
		case (state_q)
			psg_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = kind ? psg_pkg::ST_PRE : psg_pkg::ST_WR;
				end
			end
			psg_pkg::ST_WR: begin
				cmd.wr  = 1'b1;
				state_d = stat.shape_wr ? psg_pkg::ST_EAPPLY : psg_pkg::ST_IDLE;
			end
			psg_pkg::ST_PRE: begin
				cmd.pre = 1'b1;
				state_d = psg_pkg::ST_NSEG;
			end
			psg_pkg::ST_NSEG: begin
				cmd.nseg = 1'b1;
				state_d  = psg_pkg::ST_VLOOP;
			end
			psg_pkg::ST_VLOOP: begin
				// one carry step per cycle until every tone counter is positive
				cmd.vstep = 1'b1;
				if (!stat.vbusy) state_d = psg_pkg::ST_VFIN;
			end
			psg_pkg::ST_VFIN: begin
				cmd.vfin = 1'b1;
				state_d  = psg_pkg::ST_NSTEP;
			end
			psg_pkg::ST_NSTEP: begin
				cmd.nstep = 1'b1;
				state_d   = stat.seg_last ? psg_pkg::ST_ENV : psg_pkg::ST_NSEG;
			end
			psg_pkg::ST_ENV: begin
				cmd.env = 1'b1;
				state_d = stat.env_go ? psg_pkg::ST_ELOOP : psg_pkg::ST_MIX;
			end
			psg_pkg::ST_ELOOP: begin
				cmd.estep = 1'b1;
				if (!stat.env_more) state_d = psg_pkg::ST_EFIN;
			end
			psg_pkg::ST_EFIN: begin
				cmd.efin = 1'b1;
				state_d  = psg_pkg::ST_EAPPLY;
			end
			psg_pkg::ST_EAPPLY: begin
				cmd.eapply = 1'b1;
				state_d    = kind_q ? psg_pkg::ST_MIX : psg_pkg::ST_IDLE;
			end
			psg_pkg::ST_MIX: begin
				cmd.mix = 1'b1;
				if (mix_q == 2'd2) state_d = psg_pkg::ST_OUT;
			end
			psg_pkg::ST_OUT: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = psg_pkg::ST_IDLE;
				end
			end
			default: state_d = psg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psg_pkg::ST_IDLE;
			kind_q  <= 1'b0;
			mix_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cmd.load) kind_q <= kind;
			if (cmd.mix) mix_q <= mix_q + 2'd1;
			else mix_q <= 2'd0;
		end
	end

endmodule

// ----- hw/rtl/psg_dp.sv -----
// ----------------------------------------------------------------------------
// psg_dp
// Datapath: sound registers, tone/noise/envelope counters, mixer and output.
// ----------------------------------------------------------------------------
module psg_dp #(
	parameter int U = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  psg_pkg::cmd_t  cmd,
	input  logic [3:0]     reg_addr,
	input  logic [7:0]     reg_data,
	input  logic           out_ready,
	output psg_pkg::stat_t stat,
	output logic           out_valid,
	output logic [7:0]     sample
);

	localparam int TCW = $clog2(4096 + 4 * U) + 2;
	localparam int NCW = $clog2(32 + 4 * U) + 2;
	localparam int ECW = $clog2(65536 + 4 * U) + 2;
	localparam int LW  = $clog2(U + 1);

	localparam logic signed [TCW-1:0] TU = TCW'(U);
	localparam logic signed [NCW-1:0] NU = NCW'(U);
	localparam logic signed [ECW-1:0] EU = ECW'(U);
	localparam logic [LW-1:0]         LU = LW'(U);

	logic [7:0]               regs_q [16];
	logic [11:0]              tp_q   [3];
	logic signed [TCW-1:0]    tc_q   [3];
	logic [2:0]               tl_q;
	logic [31:0]              acc_q  [3];
	logic [4:0]               np_q;
	logic signed [NCW-1:0]    nc_q;
	logic                     nl_q;
	logic [16:0]              ns_q;
	logic [15:0]              ep_q;
	logic signed [ECW-1:0]    ec_q;
	logic signed [6:0]        es_q;
	logic                     hold_q, alt_q, holding_q;
	logic [4:0]               att_q;
	logic [7:0]               vol_q  [3];
	logic [2:0]               vmode_q;
	logic [7:0]               evol_q;
	logic [LW-1:0]            left_q, ne_q;
	logic [31:0]              sum_q;
	logic                     ovalid_q;
	logic [3:0]               addr_q;
	logic [7:0]               data_q;
	logic [7:0]               sample_q;

	logic [7:0]               en;
	logic [2:0]               weigh;
	logic [11:0]              tpe    [3];
	logic signed [TCW-1:0]    tps    [3];
	logic signed [TCW-1:0]    t_c1   [3];
	logic [7:0]               fine_b [3];
	logic [3:0]               coarse_b [3];
	logic [11:0]              tnp    [3];
	logic signed [TCW-1:0]    t_sum  [3];
	logic signed [TCW-1:0]    t_res  [3];
	logic [4:0]               nnew, npe;
	logic signed [NCW-1:0]    n_sum, n_res, n_cut;
	logic [LW-1:0]            ne_c;
	logic [15:0]              enp, enew, epe;
	logic signed [ECW-1:0]    e_sum, e_res, epe_s;
	logic [7:0]               ev;
	logic [31:0]              acc_sel;
	logic [7:0]               vol_sel;
	logic [31:0]              prod;

	always_comb begin
		en = regs_q[psg_pkg::REG_ENABLE];
		for (int v = 0; v < 3; v++) begin
			weigh[v]    = nl_q | en[3+v];
			tpe[v]      = (tp_q[v] == 12'd0) ? 12'd1 : tp_q[v];
			tps[v]      = $signed(TCW'(tpe[v]));
			t_c1[v]     = tc_q[v] + tps[v];
			fine_b[v]   = (addr_q == 4'(2 * v)) ? data_q : regs_q[4'(2 * v)];
			coarse_b[v] = (addr_q == 4'(2 * v + 1)) ? data_q[3:0] : regs_q[4'(2 * v + 1)][3:0];
			tnp[v]      = {coarse_b[v], fine_b[v]};
			if (tnp[v] == 12'd0) tnp[v] = 12'd1;
			t_sum[v]    = tc_q[v] + $signed(TCW'(tnp[v])) - $signed(TCW'(tp_q[v]));
			t_res[v]    = (t_sum[v] <= 0) ? TCW'(1) : t_sum[v];
		end

		nnew  = (data_q[4:0] == 5'd0) ? 5'd1 : data_q[4:0];
		npe   = (np_q == 5'd0) ? 5'd1 : np_q;
		n_sum = nc_q + $signed(NCW'(nnew)) - $signed(NCW'(np_q));
		n_res = (n_sum <= 0) ? NCW'(1) : n_sum;
		ne_c  = (nc_q < $signed(NCW'(left_q))) ? nc_q[LW-1:0] : left_q;
		n_cut = nc_q - $signed(NCW'(ne_q));

		enp   = {(addr_q == psg_pkg::REG_ENV_HI) ? data_q : regs_q[psg_pkg::REG_ENV_HI],
		         (addr_q == psg_pkg::REG_ENV_LO) ? data_q : regs_q[psg_pkg::REG_ENV_LO]};
		enew  = (enp == 16'd0) ? 16'd1 : enp;
		e_sum = ec_q + $signed(ECW'(enew)) - $signed(ECW'(ep_q));
		e_res = (e_sum <= 0) ? ECW'(1) : e_sum;
		epe   = (ep_q == 16'd0) ? 16'd1 : ep_q;
		epe_s = $signed(ECW'(epe));
		ev    = psg_pkg::level(es_q[4:0] ^ att_q);

		case (cmd.mix_idx)
			2'd1: begin
				acc_sel = acc_q[1];
				vol_sel = vol_q[1];
			end
			2'd2: begin
				acc_sel = acc_q[2];
				vol_sel = vol_q[2];
			end
			default: begin
				acc_sel = acc_q[0];
				vol_sel = vol_q[0];
			end
		endcase
		prod = acc_sel * 32'(vol_sel);

		stat.shape_wr = (addr_q == psg_pkg::REG_SHAPE);
		stat.vbusy    = (tc_q[0] <= 0) || (tc_q[1] <= 0) || (tc_q[2] <= 0);
		stat.seg_last = (left_q == ne_q);
		stat.env_go   = !holding_q && ((ec_q - EU) <= 0);
		stat.env_more = ((ec_q + epe_s) <= 0);
		stat.out_free = !ovalid_q || out_ready;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= reg_addr;
			data_q <= reg_data;
		end
		if (cmd.nseg) ne_q <= ne_c;
		if (cmd.out_load) sample_q <= (|sum_q[31:9]) ? 8'hff : sum_q[8:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) regs_q[i] <= 8'd0;
			for (int v = 0; v < 3; v++) begin
				tp_q[v]  <= '0;
				tc_q[v]  <= '0;
				acc_q[v] <= '0;
				vol_q[v] <= '0;
			end
			tl_q      <= '0;
			vmode_q   <= '0;
			np_q      <= '0;
			nc_q      <= '0;
			nl_q      <= 1'b0;
			ns_q      <= '0;
			ep_q      <= '0;
			ec_q      <= '0;
			es_q      <= '0;
			hold_q    <= 1'b0;
			alt_q     <= 1'b0;
			holding_q <= 1'b0;
			att_q     <= '0;
			evol_q    <= '0;
			left_q    <= '0;
			sum_q     <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cmd.wr) begin
				case (addr_q) inside
					4'd1, 4'd3, 4'd5, psg_pkg::REG_SHAPE: regs_q[addr_q] <= {4'd0, data_q[3:0]};
					psg_pkg::REG_NOISE, 4'd8, 4'd9, 4'd10: regs_q[addr_q] <= {3'd0, data_q[4:0]};
					default: regs_q[addr_q] <= data_q;
				endcase
				for (int v = 0; v < 3; v++) begin
					if (addr_q[3:1] == 3'(v)) begin
						tp_q[v] <= tnp[v];
						tc_q[v] <= t_res[v];
					end
					if (addr_q == 4'(8 + v)) begin
						vmode_q[v] <= data_q[4];
						if (data_q[4]) vol_q[v] <= evol_q;
						else if (data_q[3:0] == 4'd0) vol_q[v] <= psg_pkg::level(5'd0);
						else vol_q[v] <= psg_pkg::level({data_q[3:0], 1'b1});
					end
				end
				if (addr_q == psg_pkg::REG_NOISE) begin
					np_q <= nnew;
					nc_q <= n_res;
				end
				if (addr_q == psg_pkg::REG_ENV_LO || addr_q == psg_pkg::REG_ENV_HI) begin
					ep_q <= enew;
					ec_q <= e_res;
				end
				if (addr_q == psg_pkg::REG_SHAPE) begin
					att_q <= data_q[2] ? 5'h1f : 5'h00;
					if (!data_q[3]) begin
						hold_q <= 1'b1;
						alt_q  <= data_q[2];
					end else begin
						hold_q <= data_q[0];
						alt_q  <= data_q[1];
					end
					ec_q      <= $signed(ECW'(ep_q));
					es_q      <= 7'sd31;
					holding_q <= 1'b0;
				end
			end

			if (cmd.pre) begin
				// carry silent or disabled voices across the sample
				for (int v = 0; v < 3; v++) begin
					if ((en[v] || regs_q[4'(8 + v)] == 8'd0) && tc_q[v] <= TU)
						tc_q[v] <= tc_q[v] + TU;
					if (en[v]) tl_q[v] <= 1'b1;
					acc_q[v] <= '0;
				end
				if (en[5:3] == 3'b111 && nc_q <= NU) nc_q <= nc_q + NU;
				left_q <= LU;
				sum_q  <= '0;
			end

			if (cmd.nseg) begin
				for (int v = 0; v < 3; v++) begin
					if (weigh[v] && tl_q[v]) acc_q[v] <= acc_q[v] + 32'(tc_q[v]);
					tc_q[v] <= tc_q[v] - $signed(TCW'(ne_c));
				end
			end

			if (cmd.vstep) begin
				for (int v = 0; v < 3; v++) begin
					if (tc_q[v] <= 0) begin
						if (t_c1[v] > 0) begin
							tc_q[v] <= t_c1[v];
							tl_q[v] <= ~tl_q[v];
							if (weigh[v] && !tl_q[v]) acc_q[v] <= acc_q[v] + 32'(tpe[v]);
						end else begin
							// a full period passes in this step: level unchanged, one high half
							tc_q[v] <= t_c1[v] + tps[v];
							if (weigh[v]) acc_q[v] <= acc_q[v] + 32'(tpe[v]);
						end
					end
				end
			end

			if (cmd.vfin) begin
				for (int v = 0; v < 3; v++)
					if (weigh[v] && tl_q[v]) acc_q[v] <= acc_q[v] - 32'(tc_q[v]);
			end

			if (cmd.nstep) begin
				left_q <= left_q - ne_q;
				if (n_cut <= 0) begin
					if (ns_q[1] ^ ns_q[0]) nl_q <= ~nl_q;
					ns_q <= (ns_q[0] ? (ns_q ^ psg_pkg::NOISE_TAPS) : ns_q) >> 1;
					nc_q <= n_cut + $signed(NCW'(npe));
				end else begin
					nc_q <= n_cut;
				end
			end

			if (cmd.env && !holding_q) ec_q <= ec_q - EU;

			if (cmd.estep) begin
				es_q <= es_q - 7'sd1;
				ec_q <= ec_q + epe_s;
			end

			if (cmd.efin && es_q[6]) begin
				if (hold_q) begin
					if (alt_q) att_q <= att_q ^ 5'h1f;
					holding_q <= 1'b1;
					es_q      <= 7'sd0;
				end else begin
					if (alt_q && es_q[5]) att_q <= att_q ^ 5'h1f;
					es_q <= {2'b00, es_q[4:0]};
				end
			end

			if (cmd.eapply) begin
				evol_q <= ev;
				for (int v = 0; v < 3; v++)
					if (vmode_q[v]) vol_q[v] <= ev;
			end

			if (cmd.mix) sum_q <= sum_q + prod;

			if (cmd.out_load) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	assign out_valid = ovalid_q;
	assign sample    = sample_q;

endmodule

// ----- hw/rtl/programmable_sound_generator.sv -----
// ----------------------------------------------------------------------------
// programmable_sound_generator
// Three square-wave voices with noise and envelope, one sample a sample request.
// ----------------------------------------------------------------------------
// A request with kind 0 writes one of the 16 sound registers; a write of the
// envelope shape also passes the envelope apply state. A request with kind 1
// produces one 8-bit sample, made of noise segments: each one passes the
// segment, tone carry loop, finish and noise step states, as the tone counters
// carry one period step per cycle; the envelope, when due, advances one step
// per cycle, and the three voices share one multiplier, taken in turn in the
// mix state. A full output register holds the sequencer until it frees. The
// next request is taken while a sample waits in the output register.
module programmable_sound_generator #(
	parameter int UNITS_PER_SAMPLE = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [3:0] reg_addr,
	input  logic [7:0] reg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] sample
);

	psg_pkg::cmd_t  cmd;
	psg_pkg::stat_t stat;

	psg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	psg_dp #(
		.U (UNITS_PER_SAMPLE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.reg_addr  (reg_addr),
		.reg_data  (reg_data),
		.out_ready (out_ready),
		.stat      (stat),
		.out_valid (out_valid),
		.sample    (sample)
	);

endmodule

// ----- hw/rtl/psg_chk.sv -----
// ----------------------------------------------------------------------------
// psg_chk
// Port-level checks of the sound generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "programmable_sound_generator_macros.svh"

module psg_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       kind,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] sample
);

	// a stalled sample holds
	`PSG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample))
	// the block is busy right after taking a request
	`PSG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// a register write never raises a sample
	`PSG_ASSERT_NEXT(a_write_no_sample, in_valid && in_ready && !kind, !$rose(out_valid))
	// a new sample is only issued from a busy cycle
	`PSG_ASSERT_NOW(a_sample_from_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind programmable_sound_generator psg_chk u_psg_chk (.*);
